### hdl/psfs_pkg.sv
package psfs_pkg;

  localparam int NUM_CH = 6;
  localparam int CH_W   = 3;

  typedef enum logic [2:0] {
    MODE_TICK = 3'd0,
    MODE_RUN1 = 3'd1,
    MODE_RUN5 = 3'd2,
    MODE_RUN6 = 3'd3,
    MODE_STOP = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_DONE    = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_BUSY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_INTERVAL   = 2'd0,
    CFG_HOLD_LONG  = 2'd1,
    CFG_HOLD_SHORT = 2'd2,
    CFG_TIMEOUT    = 2'd3
  } cfg_idx_t;

  localparam logic [7:0]  INTERVAL_RST   = 8'd30;
  localparam logic [7:0]  HOLD_LONG_RST  = 8'd30;
  localparam logic [7:0]  HOLD_SHORT_RST = 8'd20;
  localparam logic [15:0] TIMEOUT_RST    = 16'd10000;

  // channels one and four take the long hold
  localparam logic [CH_W-1:0] LONG_CH_A = 3'd1;
  localparam logic [CH_W-1:0] LONG_CH_B = 3'd4;

  typedef struct packed {
    logic [7:0]  interval_ticks;
    logic [7:0]  hold_long;
    logic [7:0]  hold_short;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [NUM_CH-1:0] pins;
    logic              busy;
    status_t           status;
  } res_t;

  // firing orders: [forward][run kind][slot]
  localparam logic [CH_W-1:0] ORDER_TAB [2][3][6] = '{
    '{ '{3'd5, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
       '{3'd2, 3'd1, 3'd4, 3'd3, 3'd5, 3'd0},
       '{3'd2, 3'd1, 3'd4, 3'd3, 3'd6, 3'd5} },
    '{ '{3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
       '{3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd0},
       '{3'd6, 3'd5, 3'd4, 3'd3, 3'd1, 3'd2} }
  };

  localparam logic [CH_W-1:0] COUNT_TAB [3] = '{3'd1, 3'd5, 3'd6};

  function automatic logic [CH_W-1:0] order_entry(logic fwd, logic [1:0] kind,
                                                  logic [CH_W-1:0] slot);
    return ORDER_TAB[fwd][kind][slot];
  endfunction

  function automatic logic [CH_W-1:0] shot_count(logic [1:0] kind);
    return COUNT_TAB[kind];
  endfunction

endpackage

### hdl/psfs_cfg.sv
module psfs_cfg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_wdata,
  output psfs_pkg::cfg_t        cfg
);
  import psfs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INTERVAL:   cfg_nxt.interval_ticks = cfg_wdata[7:0];
        CFG_HOLD_LONG:  cfg_nxt.hold_long      = cfg_wdata[7:0];
        CFG_HOLD_SHORT: cfg_nxt.hold_short     = cfg_wdata[7:0];
        CFG_TIMEOUT:    cfg_nxt.timeout_ticks  = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interval_ticks <= INTERVAL_RST;
      cfg_r.hold_long      <= HOLD_LONG_RST;
      cfg_r.hold_short     <= HOLD_SHORT_RST;
      cfg_r.timeout_ticks  <= TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hdl/psfs_core.sv
module psfs_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [2:0]       mode,
  input  logic             forward,
  input  psfs_pkg::cfg_t   cfg,
  output psfs_pkg::res_t   res_nxt
);
  import psfs_pkg::*;

  logic [7:0]        hold_r     [NUM_CH];
  logic [7:0]        hold_nxt   [NUM_CH];
  logic [CH_W-1:0]   order_r    [NUM_CH];
  logic [CH_W-1:0]   order_nxt  [NUM_CH];
  logic [NUM_CH-1:0] pins_r, pins_nxt;
  logic [CH_W-1:0]   shots_r, shots_nxt;
  logic [7:0]        ivl_r, ivl_nxt;
  logic [15:0]       elapsed_r, elapsed_nxt;
  logic              active_r, active_nxt;
  status_t           status;
  logic [8:0]        ivl_inc;
  logic [CH_W-1:0]   ch;
  logic [1:0]        kind;
  logic [CH_W-1:0]   cnt;
  logic              busy;

  always_comb begin
    hold_nxt    = hold_r;
    order_nxt   = order_r;
    pins_nxt    = pins_r;
    shots_nxt   = shots_r;
    ivl_nxt     = ivl_r;
    elapsed_nxt = elapsed_r;
    active_nxt  = active_r;
    status      = ST_NONE;
    ivl_inc     = {1'b0, ivl_r} + 9'd1;
    ch          = '0;
    kind        = mode[1:0] - 2'd1;
    cnt         = shot_count(kind);

    case (mode_t'(mode))
      MODE_TICK: begin
        if (ivl_inc >= {1'b0, cfg.interval_ticks}) begin
          ivl_nxt = '0;
          if (shots_r == '0 || shots_r > CH_W'(NUM_CH)) begin
            shots_nxt = '0;
          end else begin
            ch = order_r[shots_r - 3'd1];
            if (ch > CH_W'(NUM_CH)) begin
              shots_nxt = '0;
            end else begin
              if (ch != '0) begin
                pins_nxt[ch - 3'd1] = 1'b1;
                hold_nxt[ch - 3'd1] = (ch == LONG_CH_A || ch == LONG_CH_B) ?
                                      cfg.hold_long : cfg.hold_short;
              end
              shots_nxt = shots_r - 3'd1;
            end
          end
        end else begin
          ivl_nxt = ivl_inc[7:0];
        end
        // hold countdown, pin drops at zero
        for (int i = 0; i < NUM_CH; i++) begin
          if (hold_nxt[i] != '0) hold_nxt[i] = hold_nxt[i] - 8'd1;
          if (hold_nxt[i] == '0) pins_nxt[i] = 1'b0;
        end
        if (active_r) begin
          if (elapsed_r != '1) elapsed_nxt = elapsed_r + 16'd1;
          active_nxt = 1'b0;
          if (shots_nxt == '0) begin
            status = ST_DONE;
          end else if (elapsed_nxt >= cfg.timeout_ticks) begin
            status    = ST_TIMEOUT;
            pins_nxt  = '0;
            shots_nxt = '0;
            for (int i = 0; i < NUM_CH; i++) hold_nxt[i] = '0;
          end else begin
            active_nxt = 1'b1;
          end
        end
      end
      MODE_RUN1, MODE_RUN5, MODE_RUN6: begin
        if (shots_r != '0) begin
          status = ST_BUSY;
        end else begin
          for (int i = 0; i < NUM_CH; i++) begin
            if (CH_W'(i) < cnt) order_nxt[i] = order_entry(forward, kind, CH_W'(i));
          end
          shots_nxt   = cnt;
          ivl_nxt     = cfg.interval_ticks;
          elapsed_nxt = '0;
          active_nxt  = 1'b1;
        end
      end
      MODE_STOP: begin
        pins_nxt  = '0;
        shots_nxt = '0;
        for (int i = 0; i < NUM_CH; i++) hold_nxt[i] = '0;
      end
      default: begin
        status = ST_NONE;
      end
    endcase

    busy = (shots_nxt != '0);
    for (int i = 0; i < NUM_CH; i++) begin
      if (hold_nxt[i] != '0) busy = 1'b1;
    end
  end

  assign res_nxt.pins   = pins_nxt;
  assign res_nxt.busy   = busy;
  assign res_nxt.status = status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        hold_r[i]  <= '0;
        order_r[i] <= '0;
      end
      pins_r    <= '0;
      shots_r   <= '0;
      ivl_r     <= INTERVAL_RST;
      elapsed_r <= '0;
      active_r  <= 1'b0;
    end else if (step_en) begin
      hold_r    <= hold_nxt;
      order_r   <= order_nxt;
      pins_r    <= pins_nxt;
      shots_r   <= shots_nxt;
      ivl_r     <= ivl_nxt;
      elapsed_r <= elapsed_nxt;
      active_r  <= active_nxt;
    end
  end

endmodule

### hdl/six_channel_pulse_fire_sequencer.sv
// channel  ports                                   direction
// -------  --------------------------------------  ---------
// in       in_valid in_ready in_mode in_forward    command word in
// out      out_valid out_ready out_pins
//          out_busy_res out_status                 result word out
// cfg      cfg_we cfg_index cfg_wdata              register write
//
// one word per cycle sustained while the output is not stalled; each command word
// passes through the input register and then the output register, its result
// set by the single pass through the sequencer update logic
// rst_n is synchronous: clears counters, pins, run state, loads register defaults
// a stalled output holds its word; the input register keeps taking words as
// long as its word can move forward, so the two sides only meet through it
module six_channel_pulse_fire_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic        in_forward,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_pins,
  output logic        out_busy_res,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import psfs_pkg::*;

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [2:0] s1_mode_r;
  logic       s1_fwd_r;

  // output register
  logic       out_valid_r, out_valid_nxt;
  res_t       out_res_r;

  cfg_t cfg;
  res_t res_nxt;
  logic adv;

  // word moves from input register into state and output register
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode_r <= in_mode;
      s1_fwd_r  <= in_forward;
    end
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  psfs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sequencer state, updated once per word
  psfs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .mode    (s1_mode_r),
    .forward (s1_fwd_r),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  assign out_valid    = out_valid_r;
  assign out_pins     = out_res_r.pins;
  assign out_busy_res = out_res_r.busy;
  assign out_status   = out_res_r.status;

endmodule

### hdl/psfs_checker.sv
module psfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  out_pins,
  input logic        out_busy_res,
  input logic [1:0]  out_status
);
  import psfs_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pins) &&
    $stable(out_busy_res) && $stable(out_status))
    else $error("stalled result word changed");

  // input side only stalls behind a stalled output
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // a lit pin always has a running hold
  a_pin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pins != '0 |-> out_busy_res)
    else $error("pin on while not busy");

  // timeout clears everything
  a_timeout_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_TIMEOUT |-> out_pins == '0 && !out_busy_res)
    else $error("timeout left outputs on");

  // a rejected run means shots were pending
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BUSY |-> out_busy_res)
    else $error("run rejected while idle");

endmodule

bind six_channel_pulse_fire_sequencer psfs_checker u_psfs_checker (.*);

### dv/testbench.sv
module testbench;
  import psfs_pkg::*;

  // mode codes past stop that the block must ignore
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  // simulation watchdog limit, far above the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned DRAIN_LIMIT = 5_000;

  // firing orders indexed [forward][run kind][slot], shots taken from the top slot down
  localparam bit [2:0] SHOT_ORDER [2][3][NUM_CH] = '{
    '{ '{3'd5, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
       '{3'd2, 3'd1, 3'd4, 3'd3, 3'd5, 3'd0},
       '{3'd2, 3'd1, 3'd4, 3'd3, 3'd6, 3'd5} },
    '{ '{3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
       '{3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd0},
       '{3'd6, 3'd5, 3'd4, 3'd3, 3'd1, 3'd2} }
  };
  localparam bit [2:0] SHOT_COUNT [3] = '{3'd1, 3'd5, 3'd6};

  // sequencer prediction plus the queue of result words still owed by the block
  class fire_scoreboard;
    bit [7:0]        interval_ticks = INTERVAL_RST;
    bit [7:0]        hold_long      = HOLD_LONG_RST;
    bit [7:0]        hold_short     = HOLD_SHORT_RST;
    bit [15:0]       timeout_ticks  = TIMEOUT_RST;
    bit [7:0]        hold_cnt [NUM_CH];
    bit [2:0]        order [NUM_CH];
    bit [NUM_CH-1:0] pins;
    bit [2:0]        shots_left;
    bit [7:0]        interval_cnt   = INTERVAL_RST;
    bit [15:0]       elapsed;
    bit              run_on;
    res_t            expected_words [$];
    int              errors;

    function void set_regs(bit [7:0] iv, bit [7:0] hl, bit [7:0] hs, bit [15:0] to);
      interval_ticks = iv;
      hold_long      = hl;
      hold_short     = hs;
      timeout_ticks  = to;
    endfunction

    function void drop_all();
      foreach (hold_cnt[i]) hold_cnt[i] = '0;
      pins       = '0;
      shots_left = '0;
    endfunction

    function void fire_shot();
      bit [2:0] ch;
      int       idx;
      if (shots_left == 0 || shots_left > NUM_CH) begin
        shots_left = '0;
        return;
      end
      ch = order[shots_left - 1];
      if (ch > NUM_CH) begin
        shots_left = '0;
        return;
      end
      if (ch != 0) begin
        idx = ch - 1;
        pins[idx]     = 1'b1;
        hold_cnt[idx] = (idx == 0 || idx == 3) ? hold_long : hold_short;
      end
      shots_left--;
    endfunction

    function status_t advance_tick();
      int unsigned nxt;
      nxt = interval_cnt + 1;
      if (nxt >= interval_ticks) begin
        interval_cnt = '0;
        fire_shot();
      end else begin
        interval_cnt = nxt[7:0];
      end
      // holds count down after the shot, so a hold of one drops at once
      foreach (hold_cnt[i]) begin
        if (hold_cnt[i] > 0) hold_cnt[i]--;
        if (hold_cnt[i] == 0) pins[i] = 1'b0;
      end
      if (!run_on) return ST_NONE;
      if (elapsed != 16'hffff) elapsed++;
      if (shots_left == 0) begin
        run_on = 1'b0;
        return ST_DONE;
      end
      if (elapsed >= timeout_ticks) begin
        drop_all();
        run_on = 1'b0;
        return ST_TIMEOUT;
      end
      return ST_NONE;
    endfunction

    // an accepted command word: advance the prediction, queue the result it owes
    function void note_word(logic [2:0] m, logic f);
      res_t r;
      int   k;
      int   i;
      bit   busy;
      r.status = ST_NONE;
      if (m == MODE_TICK) begin
        r.status = advance_tick();
      end else if (m >= MODE_RUN1 && m <= MODE_RUN6) begin
        if (shots_left != 0) begin
          r.status = ST_BUSY;
        end else begin
          k = m - MODE_RUN1;
          for (i = 0; i < SHOT_COUNT[k]; i++) order[i] = SHOT_ORDER[f][k][i];
          shots_left   = SHOT_COUNT[k];
          interval_cnt = interval_ticks;
          elapsed      = '0;
          run_on       = 1'b1;
        end
      end else if (m == MODE_STOP) begin
        drop_all();
      end
      busy = (shots_left != 0);
      foreach (hold_cnt[j]) if (hold_cnt[j] != 0) busy = 1'b1;
      r.pins = pins;
      r.busy = busy;
      expected_words.push_back(r);
    endfunction

    function void check_word(logic [5:0] p, logic b, logic [1:0] s);
      res_t e;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: pins %0h busy %0b status %0d", p, b, s);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      if (p !== e.pins) begin
        $error("pins: expected %0h, got %0h", e.pins, p);
        errors++;
      end
      if (b !== e.busy) begin
        $error("busy_res: expected %0b, got %0b", e.busy, b);
        errors++;
      end
      if (s !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, s);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void drain_check();
      if (expected_words.size() != 0) begin
        $error("%0d result words never arrived", expected_words.size());
        errors++;
      end
    endfunction
  endclass

  // dut signals, all inputs known from time zero
  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [2:0]  in_mode    = MODE_TICK;
  logic        in_forward = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [5:0]  out_pins;
  logic        out_busy_res;
  logic [1:0]  out_status;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = CFG_INTERVAL;
  logic [15:0] cfg_wdata  = '0;

  fire_scoreboard sb = new();

  bit          idle_en    = 1'b1;   // random gaps and stalls allowed
  int unsigned stall_left = 0;
  int unsigned cycles     = 0;
  int unsigned words_sent = 0;

  six_channel_pulse_fire_sequencer u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_forward   (in_forward),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pins     (out_pins),
    .out_busy_res (out_busy_res),
    .out_status   (out_status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side back-pressure: random stall bursts while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready  <= 1'b1;
    end
  end

  // sample both handshakes with pre-edge values; an input word always lands
  // before its result, so the order of these two blocks does not matter
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_word(in_mode, in_forward);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_pins, out_busy_res, out_status);
  end

  // present one command word, optionally after an idle burst, and hold it until taken
  task automatic send_word(input logic [2:0] m, input logic f);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= m;
    in_forward <= f;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // wait until every result word is back and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all four registers back to back, block idle
  task automatic write_regs(input bit [7:0] iv, input bit [7:0] hl, input bit [7:0] hs,
                            input bit [15:0] to);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INTERVAL;
    cfg_wdata <= {8'h00, iv};
    @(posedge clk);
    cfg_index <= CFG_HOLD_LONG;
    cfg_wdata <= {8'h00, hl};
    @(posedge clk);
    cfg_index <= CFG_HOLD_SHORT;
    cfg_wdata <= {8'h00, hs};
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT;
    cfg_wdata <= to;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_regs(iv, hl, hs, to);
  endtask

  // a run command followed by enough ticks to usually finish it,
  // sprinkled with stray commands (rejected runs, stops, spare codes)
  task automatic run_sequence(input int unsigned tick_cap);
    int unsigned span;
    int unsigned n;
    span = 7 * (sb.interval_ticks + 1) + sb.hold_long + sb.hold_short;
    n = $urandom_range(span / 2, span);
    if (n > tick_cap) n = tick_cap;
    send_word(3'($urandom_range(MODE_RUN1, MODE_RUN6)), 1'($urandom_range(0, 1)));
    repeat (n) begin
      if ($urandom_range(0, 24) == 0)
        send_word(3'($urandom_range(MODE_RUN1, MODE_SPARE_HI)), 1'($urandom_range(0, 1)));
      else
        send_word(MODE_TICK, 1'($urandom_range(0, 1)));
    end
  endtask

  // mostly well-formed runs, some pure noise words
  task automatic random_phase(input int unsigned budget, input int unsigned tick_cap,
                              input bit quiet);
    int unsigned start;
    start = words_sent;
    while (words_sent - start < budget) begin
      idle_en <= !quiet && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) begin
        run_sequence(tick_cap);
      end else begin
        repeat ($urandom_range(1, 6))
          send_word(3'($urandom_range(MODE_TICK, MODE_SPARE_HI)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int unsigned guard;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed pass on reset register values
    send_word(MODE_TICK, 1'b0);       // tick with nothing armed
    send_word(MODE_RUN6, 1'b1);       // six-shot run, forward order set
    send_word(MODE_RUN1, 1'b0);       // rejected while shots pending
    send_word(MODE_TICK, 1'b1);       // first shot fires right away
    send_word(MODE_TICK, 1'b0);
    send_word(MODE_STOP, 1'b1);       // clears pins, run stays active
    send_word(MODE_TICK, 1'b0);       // so the run reports done here
    send_word(MODE_SPARE_LO, 1'b0);   // spare codes change nothing
    send_word(MODE_SPARE_HI, 1'b1);
    send_word(MODE_RUN1, 1'b0);       // single shot
    send_word(MODE_TICK, 1'b0);       // fires and finishes in one tick
    send_word(MODE_RUN5, 1'b1);       // accepted while a hold still runs
    send_word(MODE_TICK, 1'b0);
    send_word(MODE_RUN5, 1'b0);       // rejected
    send_word(MODE_STOP, 1'b0);
    send_word(MODE_TICK, 1'b1);
    send_word(MODE_RUN5, 1'b0);
    send_word(MODE_TICK, 1'b0);
    send_word(MODE_TICK, 1'b1);
    send_word(MODE_STOP, 1'b0);
    send_word(MODE_TICK, 1'b0);
    send_word(MODE_RUN1, 1'b1);
    send_word(MODE_TICK, 1'b0);
    send_word(MODE_TICK, 1'b1);

    // shortest interval and holds: a hold of one drops in the tick it fires
    settle();
    write_regs(8'd1, 8'd1, 8'd1, 16'hffff);
    random_phase(100, 150, 1'b0);

    // interval of zero fires on every tick
    settle();
    write_regs(8'd0, 8'd2, 8'd3, 16'd100);
    random_phase(100, 150, 1'b0);

    // timeout shorter than a full run
    settle();
    write_regs(8'd5, 8'd9, 8'd4, 16'd12);
    random_phase(100, 150, 1'b0);

    // widest interval and holds, runs are slow so keep this short
    settle();
    write_regs(8'd255, 8'd255, 8'd255, 16'hffff);
    random_phase(60, 100, 1'b0);

    // random settings, no idling on either side till the end
    settle();
    write_regs(8'($urandom_range(1, 40)), 8'($urandom_range(1, 60)),
               8'($urandom_range(1, 60)), 16'($urandom_range(8, 300)));
    random_phase(80, 60, 1'b1);

    in_valid <= 1'b0;
    idle_en  <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    sb.drain_check();

    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
